// File: hdl/pidaw_pkg.sv
// shared widths, register indexes and sequencer states of the pid controller
package pidaw_pkg;

  // field widths, q16.16 format
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned FRAC_W    = 16;

  // shared multiplier: 33 bit signed operands cover a negated rate of -2^31
  localparam int unsigned MUL_W     = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned SUM_W     = PROD_W - FRAC_W;

  // rate divider: |delta| (33 bit) shifted up by the fraction bits
  localparam int unsigned DIV_W     = DATA_W + 1 + FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned REM_W     = STEP_W;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUM = 3'd5;

  // op codes of an input word
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // rate saturation bounds as multiplier operands
  localparam logic signed [MUL_W-1:0] RATE_POS_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [MUL_W-1:0] RATE_NEG_MAG = 33'sh0_8000_0000;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL_P,
    S_MUL_I,
    S_INTEG,
    S_MUL_KI,
    S_ADD_I,
    S_DIV_WAIT,
    S_RATE,
    S_MUL_D,
    S_ADD_D,
    S_CLAMP,
    S_WRITE
  } pid_state_t;

endpackage

// File: hdl/pidaw_mul.sv
// shared signed multiplier with a registered product
module pidaw_mul
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  // one product per cycle, ready the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: hdl/pidaw_div.sv
// bit-serial restoring divider for the measurement rate
module pidaw_div
  import pidaw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              busy,
  output logic [DIV_W-1:0]  quotient
);

  logic [REM_W-1:0]     rem;
  logic [STEP_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] count;
  logic [REM_W:0]       shifted;
  logic [REM_W+1:0]     trial;

  // partial remainder shifted by one dividend bit, then trial subtract
  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs};

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
      count <= count - DIV_CNT_W'(1);
    end
  end

  // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[REM_W+1]) begin
        rem      <= trial[REM_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[REM_W-1:0];
        quotient <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/pid_controller_antiwindup.sv
// pid controller top level: config registers, sequencer, datapath and result register
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   op, target, sample, time_step
//   result    result_valid / result_stall  drive, limited, zero_step
//   config    cfg_write                 cfg_index, cfg_data
//
// an update word with a rate term waits on the bit-serial rate divider, which runs beside
// the four passes through the shared multiplier; an update word without it (zero step,
// or first after clear or reset) skips the divider; a clear word writes a zero result.
// item_stall is high from acceptance until the result sits in the output register.
// a waiting result does not block the next word; the sequencer holds in its last
// state only while an older result is still stalled.
// rst is synchronous and restores registers and controller history.
module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // config port
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // input words
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] target,
  input  logic signed [DATA_W-1:0] sample,
  input  logic [STEP_W-1:0]        time_step,
  // result words
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] drive,
  output logic                     limited,
  output logic                     zero_step
);

  // config registers
  logic signed [DATA_W-1:0] kp;
  logic signed [DATA_W-1:0] ki;
  logic signed [DATA_W-1:0] kd;
  logic signed [DATA_W-1:0] lower_limit;
  logic signed [DATA_W-1:0] upper_limit;
  logic [STEP_W-1:0]        acc_limit;

  // controller history
  logic signed [DATA_W-1:0] error_integral;
  logic signed [DATA_W-1:0] last_sample;
  logic                     primed;

  // working registers of the current word
  pid_state_t               state;
  pid_state_t               state_next;
  logic signed [DATA_W-1:0] tgt;
  logic signed [DATA_W-1:0] smp;
  logic [STEP_W-1:0]        dt;
  logic signed [DATA_W-1:0] err;
  logic                     use_deriv;
  logic                     delta_neg;
  logic                     zstep;
  logic signed [MUL_W-1:0]  rate_term;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] res_drive;
  logic                     res_limited;

  // shared units
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_q;
  logic                     div_start;
  logic                     div_busy;
  logic [DIV_W-1:0]         div_quot;
  logic [DIV_W-1:0]         div_dividend;

  // combinational datapath pieces
  logic                     item_take;
  logic                     out_free;
  logic signed [DATA_W:0]   err_wide;
  logic signed [DATA_W-1:0] err_sat;
  logic signed [DATA_W:0]   delta;
  logic [DATA_W:0]          delta_mag;
  logic signed [DATA_W:0]   lim_pos;
  logic signed [DATA_W:0]   lim_neg;
  logic signed [DATA_W:0]   integ_old;
  logic signed [DATA_W-1:0] integ_old_clamped;
  logic signed [SUM_W-1:0]  lim_pos_w;
  logic signed [SUM_W-1:0]  lim_neg_w;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [DATA_W-1:0] integ_new;
  logic signed [SUM_W-1:0]  lower_w;
  logic signed [SUM_W-1:0]  upper_w;
  logic                     quot_big_pos;
  logic                     quot_big_neg;

  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE);

  // floor of a q16.16 product is its upper bits
  assign prod_q = prod[PROD_W-1:FRAC_W];

  // saturated error
  assign err_wide = {tgt[DATA_W-1], tgt} - {smp[DATA_W-1], smp};
  always_comb begin
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_sat = err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_sat = err_wide[DATA_W-1:0];
    end
  end

  // measurement change as a magnitude for the divider
  assign delta        = {smp[DATA_W-1], smp} - {last_sample[DATA_W-1], last_sample};
  assign delta_mag    = delta[DATA_W] ? -delta : delta;
  assign div_dividend = {delta_mag, {FRAC_W{1'b0}}};

  // old integral re-clamped to the current limit
  assign lim_pos   = {2'b00, acc_limit};
  assign lim_neg   = -lim_pos;
  assign integ_old = {error_integral[DATA_W-1], error_integral};
  always_comb begin
    if (integ_old < lim_neg) begin
      integ_old_clamped = lim_neg[DATA_W-1:0];
    end else if (integ_old > lim_pos) begin
      integ_old_clamped = lim_pos[DATA_W-1:0];
    end else begin
      integ_old_clamped = error_integral;
    end
  end

  // integral plus error times step, clamped again
  assign lim_pos_w = SUM_W'(lim_pos);
  assign lim_neg_w = -lim_pos_w;
  assign integ_sum = SUM_W'(error_integral) + prod_q;
  always_comb begin
    if (integ_sum < lim_neg_w) begin
      integ_new = lim_neg_w[DATA_W-1:0];
    end else if (integ_sum > lim_pos_w) begin
      integ_new = lim_pos_w[DATA_W-1:0];
    end else begin
      integ_new = integ_sum[DATA_W-1:0];
    end
  end

  // quotient beyond the signed 32 bit range on either side
  assign quot_big_pos = |div_quot[DIV_W-1:DATA_W-1];
  assign quot_big_neg = (|div_quot[DIV_W-1:DATA_W]) ||
                        (div_quot[DATA_W-1] && (|div_quot[DATA_W-2:0]));

  // drive limits at sum width
  assign lower_w = SUM_W'(lower_limit);
  assign upper_w = SUM_W'(upper_limit);

  // shared units
  pidaw_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  pidaw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp          <= '0;
      ki          <= '0;
      kd          <= '0;
      lower_limit <= {1'b1, {(DATA_W-1){1'b0}}};
      upper_limit <= {1'b0, {(DATA_W-1){1'b1}}};
      acc_limit   <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KP:    kp          <= cfg_data;
        REG_KI:    ki          <= cfg_data;
        REG_KD:    kd          <= cfg_data;
        REG_LOWER: lower_limit <= cfg_data;
        REG_UPPER: upper_limit <= cfg_data;
        REG_ACCUM: acc_limit   <= cfg_data[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and divider start
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (item_take) begin
          state_next = (op == OP_CLEAR) ? S_WRITE : S_PREP;
        end
      end
      S_PREP: begin
        div_start  = (dt != '0) && primed;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        mul_a      = MUL_W'(kp);
        mul_b      = MUL_W'(err);
        state_next = S_MUL_I;
      end
      S_MUL_I: begin
        mul_a      = MUL_W'(err);
        mul_b      = {2'b00, dt};
        state_next = S_INTEG;
      end
      S_INTEG: begin
        state_next = S_MUL_KI;
      end
      S_MUL_KI: begin
        mul_a      = MUL_W'(ki);
        mul_b      = MUL_W'(error_integral);
        state_next = S_ADD_I;
      end
      S_ADD_I: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!use_deriv) begin
          state_next = S_CLAMP;
        end else if (!div_busy) begin
          state_next = S_RATE;
        end
      end
      S_RATE: begin
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        mul_a      = MUL_W'(kd);
        mul_b      = rate_term;
        state_next = S_ADD_D;
      end
      S_ADD_D: begin
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // controller history
  always_ff @(posedge clk) begin
    if (rst) begin
      error_integral <= '0;
      last_sample    <= '0;
      primed         <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take && (op == OP_CLEAR)) begin
            error_integral <= '0;
            last_sample    <= '0;
            primed         <= 1'b0;
          end
        end
        S_PREP:  error_integral <= integ_old_clamped;
        S_INTEG: error_integral <= integ_new;
        S_CLAMP: begin
          last_sample <= smp;
          primed      <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_take) begin
          tgt         <= target;
          smp         <= sample;
          dt          <= time_step;
          res_drive   <= '0;
          res_limited <= 1'b0;
          zstep       <= 1'b0;
        end
      end
      S_PREP: begin
        err       <= err_sat;
        use_deriv <= (dt != '0) && primed;
        delta_neg <= delta[DATA_W];
        zstep     <= (dt == '0);
        sum       <= '0;
      end
      S_MUL_I:  sum <= prod_q;
      S_ADD_I:  sum <= sum + prod_q;
      S_RATE: begin
        // truncated quotient, saturated, then negated for the minus kd term
        if (!delta_neg) begin
          rate_term <= quot_big_pos ? -RATE_POS_MAX : -$signed(div_quot[MUL_W-1:0]);
        end else begin
          rate_term <= quot_big_neg ? RATE_NEG_MAG : $signed(div_quot[MUL_W-1:0]);
        end
      end
      S_ADD_D:  sum <= sum + prod_q;
      S_CLAMP: begin
        if (sum < lower_w) begin
          res_drive   <= lower_limit;
          res_limited <= 1'b1;
        end else if (sum > upper_w) begin
          res_drive   <= upper_limit;
          res_limited <= 1'b1;
        end else begin
          res_drive   <= sum[DATA_W-1:0];
          res_limited <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_WRITE) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WRITE) && out_free) begin
      drive     <= res_drive;
      limited   <= res_limited;
      zero_step <= zstep;
    end
  end

`ifndef SYNTH
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (item_take && (op == OP_CLEAR)) |=>
      (res_drive == '0 && !res_limited && !zstep && state == S_WRITE))
    else $error("clear word did not stage a zero result");

  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_INTEG) |=>
      ($signed({error_integral[DATA_W-1], error_integral}) <= lim_pos &&
       $signed({error_integral[DATA_W-1], error_integral}) >= lim_neg))
    else $error("integral left its limit after update");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_busy)
    else $error("divider still busy while sequencer idle");
`endif

endmodule

// File: test/pid_controller_antiwindup_tb.sv
`timescale 1ns / 100ps
// testbench for the pid controller: directed and random words checked against a q16.16 predictor
module pid_controller_antiwindup_tb
  import pidaw_pkg::*;
();

  localparam int     CYCLE_LIMIT   = 1_000_000;
  localparam int     HOLD_CYCLES   = 1500;
  localparam int     SETTLE_CYCLES = 80;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_WORDS   = 75;
  localparam longint Q_MAX         = 64'sd2147483647;
  localparam longint Q_MIN         = -64'sd2147483648;

  // one expected result word
  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     limited;
    logic                     zero_step;
  } drive_word_t;

  // predicts the drive of each accepted word and checks the result words in order
  class drive_checker;
    longint      kp, ki, kd, lower, upper, accum_max;
    longint      integral, last_meas;
    bit          primed;
    drive_word_t pending_drives[$];
    int          failures;

    function new();
      kp = 0;
      ki = 0;
      kd = 0;
      lower = Q_MIN;
      upper = Q_MAX;
      accum_max = Q_MAX;
      integral = 0;
      last_meas = 0;
      primed = 0;
      failures = 0;
    endfunction

    // q16.16 product scaling, rounds toward minus infinity
    function longint q16(longint v);
      return v >>> FRAC_W;
    endfunction

    function longint sat32(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint clamp_sym(longint v, longint bound);
      if (v < -bound) return -bound;
      if (v > bound) return bound;
      return v;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_KP:    kp = longint'(signed'(data));
        REG_KI:    ki = longint'(signed'(data));
        REG_KD:    kd = longint'(signed'(data));
        REG_LOWER: lower = longint'(signed'(data));
        REG_UPPER: upper = longint'(signed'(data));
        REG_ACCUM: accum_max = longint'(data[STEP_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_word(logic opc, logic signed [DATA_W-1:0] tgt,
                            logic signed [DATA_W-1:0] smp, logic [STEP_W-1:0] dt);
      longint      err, integ, p_term, i_term, d_term, total, step, rate;
      drive_word_t want;
      want = '0;
      // clear word empties the history and answers with zero
      if (opc == OP_CLEAR) begin
        integral = 0;
        last_meas = 0;
        primed = 0;
        pending_drives.push_back(want);
        return;
      end
      step = longint'(dt);
      err = sat32(longint'(tgt) - longint'(smp));
      p_term = q16(kp * err);
      // old integral is clipped to the current bound before the new area is added
      integ = clamp_sym(integral, accum_max);
      integ = clamp_sym(integ + q16(err * step), accum_max);
      integral = integ;
      i_term = q16(ki * integ);
      // derivative on measurement, skipped when unprimed or on a zero step
      d_term = 0;
      if (step == 0) begin
        want.zero_step = 1'b1;
      end else if (primed) begin
        rate = sat32(((longint'(smp) - last_meas) * 65536) / step);
        d_term = q16(-(kd * rate));
      end
      last_meas = longint'(smp);
      primed = 1;
      // output clamp, the lower bound is tested first
      total = p_term + i_term + d_term;
      if (total < lower) begin
        total = lower;
        want.limited = 1'b1;
      end else if (total > upper) begin
        total = upper;
        want.limited = 1'b1;
      end
      want.drive = total[DATA_W-1:0];
      pending_drives.push_back(want);
    endfunction

    function void check_word(logic signed [DATA_W-1:0] drv, logic lim, logic zs);
      drive_word_t want;
      if (pending_drives.size() == 0) begin
        failures++;
        $display("%0t: result word with none pending, actual drive %h limited %b zero_step %b",
                 $time, drv, lim, zs);
        return;
      end
      want = pending_drives.pop_front();
      if (drv !== want.drive) begin
        failures++;
        $display("%0t: drive expected %h actual %h", $time, want.drive, drv);
      end
      if (lim !== want.limited) begin
        failures++;
        $display("%0t: limited expected %b actual %b", $time, want.limited, lim);
      end
      if (zs !== want.zero_step) begin
        failures++;
        $display("%0t: zero_step expected %b actual %b", $time, want.zero_step, zs);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;
  logic                     item_valid;
  logic                     item_stall;
  logic                     op;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] sample;
  logic [STEP_W-1:0]        time_step;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [DATA_W-1:0] drive;
  logic                     limited;
  logic                     zero_step;

  drive_checker tracker = new();
  bit           pace_items = 1'b0;
  bit           pace_results = 1'b0;
  bit           hold_request = 1'b0;
  int unsigned  cycle_count = 0;

  pid_controller_antiwindup dut (.*);

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // watch both handshakes; results are checked before the new word is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) tracker.check_word(drive, limited, zero_step);
      if (item_valid && !item_stall) tracker.note_word(op, target, sample, time_step);
    end
  end

  // idle lengths: mostly short, a few long
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 3);
    if (pick < 96) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    if (pick < 4) return $urandom;
    return $urandom_range(0, 'h0040_0000) - 'h0020_0000;
  endfunction

  function automatic logic [DATA_W-1:0] random_gain();
    if ($urandom_range(0, 9) < 3) return $urandom;
    return $urandom_range(0, 'h0004_0000) - 'h0002_0000;
  endfunction

  // result side stalls, with one long hold-off on request
  initial begin : result_pacing
    int run;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        run = HOLD_CYCLES;
      end else if (pace_results) begin
        result_stall <= ($urandom_range(0, 2) == 0);
        run = 1 + gap_length();
      end else begin
        result_stall <= 1'b0;
        run = 1;
      end
      repeat (run - 1) @(posedge clk);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [DATA_W-1:0] p_gain, input logic [DATA_W-1:0] i_gain,
                           input logic [DATA_W-1:0] d_gain, input logic [DATA_W-1:0] lo,
                           input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] accum);
    write_reg(REG_KP, p_gain);
    write_reg(REG_KI, i_gain);
    write_reg(REG_KD, d_gain);
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
    write_reg(REG_ACCUM, accum);
  endtask

  task automatic random_regs();
    logic [DATA_W-1:0] lo, hi, accum;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      lo = 32'h8000_0000;
      hi = 32'h7FFF_FFFF;
    end else if (pick < 4) begin
      // crossed limits
      lo = $urandom_range(0, 'h0020_0000);
      hi = 0 - $urandom_range(0, 'h0020_0000);
    end else if (pick == 4) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      lo = 0 - $urandom_range(0, 'h0100_0000);
      hi = $urandom_range(0, 'h0100_0000);
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) accum = '0;
    else if (pick == 1) accum = 32'h7FFF_FFFF;
    else if (pick == 2) accum = $urandom & 32'h7FFF_FFFF;
    else accum = $urandom_range(0, 'h0080_0000);
    load_regs(random_gain(), random_gain(), random_gain(), lo, hi, accum);
  endtask

  // offer one word and hold it until taken
  task automatic send_word(input logic opc, input logic signed [DATA_W-1:0] tgt,
                           input logic signed [DATA_W-1:0] smp, input logic [STEP_W-1:0] dt);
    item_valid <= 1'b1;
    op <= opc;
    target <= tgt;
    sample <= smp;
    time_step <= dt;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic pause_items(input int cycles);
    if (cycles > 0) begin
      item_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop offering until every pending result has come back
  task automatic drain_results();
    if (item_valid) item_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_drives.size() != 0);
  endtask

  task automatic send_random_word();
    logic signed [DATA_W-1:0] tgt, smp;
    logic [STEP_W-1:0]        dt;
    logic                     opc;
    int                       pick;
    opc = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_UPDATE;
    tgt = random_value();
    smp = $urandom_range(0, 1) ? random_value() : tgt + $urandom_range(0, 'h8000) - 'h4000;
    pick = $urandom_range(0, 19);
    if (pick < 2) dt = '0;
    else if (pick == 2) dt = 31'h7FFF_FFFF;
    else if (pick < 5) dt = STEP_W'($urandom);
    else if (pick == 5) dt = 31'h0000_0001;
    else dt = STEP_W'($urandom_range(1, 'h0002_0000));
    send_word(opc, tgt, smp, dt);
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_valid <= 1'b0;
    op <= OP_UPDATE;
    target <= '0;
    sample <= '0;
    time_step <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: zero gains, open limits, unprimed zero step
    send_word(OP_UPDATE, 32'sh0005_0000, 32'sh0001_0000, '0);
    send_word(OP_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    drain_results();

    // moderate gains, drive within +/-100, integral within +/-50
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'hFF9C_0000, 32'h0064_0000,
              32'h0032_0000);
    send_word(OP_CLEAR, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_word(OP_UPDATE, 32'sh0002_0000, 32'sh0001_0000, 31'h0001_0000);
    send_word(OP_UPDATE, 32'sh0002_0000, 32'sh0001_8000, 31'h0000_8000);
    send_word(OP_UPDATE, 32'sh0002_0000, 32'sh0001_4000, '0);
    // error saturation both ways, integral and drive clamps
    send_word(OP_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_word(OP_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    // rate saturation both ways
    send_word(OP_UPDATE, '0, 32'sh8000_0000, 31'h0000_0001);
    send_word(OP_UPDATE, '0, 32'sh7FFF_FFFF, 31'h0000_0001);
    send_word(OP_UPDATE, '0, '0, '0);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_UPDATE, 32'shFFFD_0000, 32'sh0004_0000, 31'h0000_4000);
    send_word(OP_UPDATE, 32'sh0100_0000, '0, 31'h0001_0000);
    drain_results();

    // stored integral above a lowered bound is clipped before use
    write_reg(REG_ACCUM, 32'h0002_0000);
    send_word(OP_UPDATE, '0, '0, '0);
    drain_results();

    // crossed drive limits, no integral room
    load_regs(32'h0001_0000, '0, '0, 32'h000A_0000, 32'hFFF6_0000, '0);
    send_word(OP_UPDATE, '0, '0, 31'h0001_0000);
    send_word(OP_UPDATE, 32'sh0014_0000, '0, 31'h0001_0000);
    drain_results();

    // extreme gains
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    send_word(OP_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_word(OP_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0000_0001);
    drain_results();
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0);
    send_word(OP_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h0000_0001);
    send_word(OP_UPDATE, 32'sh0000_0001, '0, 31'h7FFF_FFFF);

    // random phases, each with its own register set and idling mix
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      random_regs();
      pace_items = (phase % 4) < 2;
      pace_results = (phase % 4 == 0) || (phase % 4 == 2);
      if (phase % 4 == 3) hold_request = 1'b1;
      repeat (PHASE_WORDS) begin
        send_random_word();
        if ($urandom_range(0, 49) == 0) drain_results();
        else if (pace_items) pause_items(gap_length());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_drives.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
